[design/smf_pkg.sv]
// Package: constants and types shared by the sliding median filter modules.
`default_nettype none
package smf_pkg;

  localparam int WINDOW   = 11;
  localparam int HALF     = WINDOW / 2;
  localparam int TAPS     = HALF + 1;
  localparam int SAMPLE_W = 32;
  localparam int AGE_W    = $clog2(WINDOW);
  localparam int SEEN_W   = $clog2(WINDOW + 1);
  localparam int K_W      = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_sequence;
  } smf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } smf_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } smf_entry_t;

  typedef struct packed {
    logic       lt;
    smf_entry_t entry;
  } smf_slot_t;

endpackage
`default_nettype wire

[design/smf_cell.sv]
// One cell of the sorted window chain: holds one sample and its age.
`default_nettype none
module smf_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                shift_en,
  input  wire logic signed [smf_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [smf_pkg::AGE_W-1:0]           init_age,
  input  wire logic                                dl_in,
  input  wire smf_pkg::smf_slot_t                  right,
  input  wire smf_pkg::smf_slot_t                  left_rem,
  output      smf_pkg::smf_slot_t                  own,
  output      smf_pkg::smf_slot_t                  rem,
  output      logic                                dl_out
);

  smf_pkg::smf_entry_t entry_r;
  smf_pkg::smf_entry_t entry_nxt;
  logic                lt;

  assign lt        = $signed(sample) < $signed(entry_r.value);
  assign own.lt    = lt;
  assign own.entry = entry_r;
  assign dl_out    = dl_in | (entry_r.age == smf_pkg::AGE_LAST);

  // close the gap left by the evicted entry
  assign rem.lt    = dl_out ? right.lt : lt;
  assign rem.entry = dl_out ? right.entry : entry_r;

  always_comb begin
    if (!rem.lt) begin
      entry_nxt.value = rem.entry.value;
      entry_nxt.age   = rem.entry.age + smf_pkg::AGE_W'(1);
    end else if (!left_rem.lt) begin
      entry_nxt.value = sample;
      entry_nxt.age   = '0;
    end else begin
      entry_nxt.value = left_rem.entry.value;
      entry_nxt.age   = left_rem.entry.age + smf_pkg::AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.value <= '0;
      entry_r.age   <= init_age;
    end else if (shift_en) begin
      entry_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

[design/smf_out_fifo.sv]
// Two-entry output queue between the result stage and the output channel.
`default_nettype none
module smf_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire smf_pkg::smf_out_t push_data,
  output      logic              full,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      smf_pkg::smf_out_t out_data
);

  smf_pkg::smf_out_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign out_valid = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/sliding_median_filter_core.sv]
// Top level: sliding median filter over a sorted chain of window cells.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_data  (smf_in_t)
//  out_    | output    | out_valid / out_ready| out_data (smf_out_t)
//
// One item per cycle; every cell compares the new sample and updates at once.
// A result waits in the pend_* registers until the output queue has room.
// A last item stalls input while held samples drain. Reset (rst_n low, synchronous)
// clears counts and queue, zeroes values, sets ages to cell index; no clear pass.
// A full output queue holds the result stage and drops in_ready.
`default_nettype none
module sliding_median_filter_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire smf_pkg::smf_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      smf_pkg::smf_out_t out_data
);

  localparam int W = smf_pkg::WINDOW;

  logic                              accept;
  logic [smf_pkg::SEEN_W-1:0]        seen_r;
  logic [smf_pkg::SEEN_W-1:0]        seen_inc;
  logic [smf_pkg::K_W-1:0]           first_k;
  logic                              pend_valid_r;
  logic                              pend_last_r;
  logic                              pend_full_r;
  logic [smf_pkg::K_W-1:0]           pend_k_r;
  logic                              pend_hold;
  logic                              push;
  logic                              fifo_full;
  smf_pkg::smf_out_t                 res;
  logic signed [smf_pkg::SAMPLE_W-1:0] tap_r [smf_pkg::TAPS];

  smf_pkg::smf_slot_t own [W];
  smf_pkg::smf_slot_t rem [W];
  logic               dl  [W+1];
  smf_pkg::smf_slot_t edge_hi;
  smf_pkg::smf_slot_t edge_lo;

  assign accept    = in_valid && in_ready;
  assign push      = pend_valid_r && !fifo_full;
  assign pend_hold = pend_last_r && (pend_k_r != '0);
  assign in_ready  = !pend_valid_r || (!fifo_full && !pend_hold);

  assign seen_inc = (seen_r == smf_pkg::SEEN_W'(W)) ? seen_r :
                    seen_r + smf_pkg::SEEN_W'(1);
  assign first_k  = (seen_inc > smf_pkg::SEEN_W'(smf_pkg::HALF)) ?
                    smf_pkg::K_W'(smf_pkg::HALF) :
                    smf_pkg::K_W'(seen_inc - smf_pkg::SEEN_W'(1));

  assign edge_lo.lt    = 1'b0;
  assign edge_lo.entry = '0;
  assign edge_hi.lt    = 1'b1;
  assign edge_hi.entry = '0;
  assign dl[0]         = 1'b0;

  for (genvar j = 0; j < W; j++) begin : g_cell
    smf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .sample   (in_data.sample_in),
      .init_age (smf_pkg::AGE_W'(j)),
      .dl_in    (dl[j]),
      .right    ((j == W - 1) ? edge_hi : own[(j == W - 1) ? j : j + 1]),
      .left_rem ((j == 0) ? edge_lo : rem[(j == 0) ? j : j - 1]),
      .own      (own[j]),
      .rem      (rem[j]),
      .dl_out   (dl[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tap_r[0] <= in_data.sample_in;
      for (int i = 1; i < smf_pkg::TAPS; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  always_comb begin
    if (pend_full_r && (pend_k_r == smf_pkg::K_W'(smf_pkg::HALF))) begin
      res.sample_out = own[smf_pkg::HALF].entry.value;
    end else begin
      res.sample_out = tap_r[pend_k_r];
    end
    res.last_out = pend_last_r && (pend_k_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      pend_valid_r <= 1'b0;
      pend_last_r  <= 1'b0;
      pend_full_r  <= 1'b0;
      pend_k_r     <= '0;
    end else if (accept) begin
      seen_r       <= in_data.end_of_sequence ? '0 : seen_inc;
      pend_valid_r <= in_data.end_of_sequence ||
                      (seen_inc > smf_pkg::SEEN_W'(smf_pkg::HALF));
      pend_last_r  <= in_data.end_of_sequence;
      pend_full_r  <= seen_inc == smf_pkg::SEEN_W'(W);
      pend_k_r     <= in_data.end_of_sequence ? first_k : smf_pkg::K_W'(smf_pkg::HALF);
    end else if (push) begin
      if (pend_hold) begin
        pend_k_r <= pend_k_r - smf_pkg::K_W'(1);
      end else begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  smf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_sequence |=> pend_valid_r && pend_last_r && seen_r == '0)
    else $error("last item did not start a drain");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= smf_pkg::SEEN_W'(W))
    else $error("seen count beyond window");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && pend_hold |-> !in_ready)
    else $error("input taken while held samples drain");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && fifo_full |=> $stable(seen_r) && pend_valid_r)
    else $error("result stage lost while output queue full");

endmodule
`default_nettype wire

[test/tb_sliding_median_filter_core.sv]
// Testbench for the sliding median filter core: streams sequences and checks every result.
`default_nettype none
module tb_sliding_median_filter_core;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  smf_pkg::smf_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  smf_pkg::smf_out_t out_data;

  sliding_median_filter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  smf_pkg::smf_out_t                   expected_samples[$];
  logic signed [smf_pkg::SAMPLE_W-1:0] window_hist[smf_pkg::WINDOW];
  int                                  seen_n = 0;
  int                                  errors = 0;
  int                                  items_sent = 0;
  int                                  quiet_cycles = 0;
  bit                                  sender_idle_en = 1'b1;
  bit                                  sink_stall_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [smf_pkg::SAMPLE_W-1:0] window_median();
    logic signed [smf_pkg::SAMPLE_W-1:0] buf_s[smf_pkg::WINDOW];
    logic signed [smf_pkg::SAMPLE_W-1:0] v;
    int j;
    buf_s = window_hist;
    for (int i = 1; i < smf_pkg::WINDOW; i++) begin
      v = buf_s[i];
      j = i - 1;
      while (j >= 0 && buf_s[j] > v) begin
        buf_s[j + 1] = buf_s[j];
        j--;
      end
      buf_s[j + 1] = v;
    end
    return buf_s[smf_pkg::HALF];
  endfunction

  task automatic predict_results(input smf_pkg::smf_in_t item);
    smf_pkg::smf_out_t res;
    int                first;
    for (int i = smf_pkg::WINDOW - 1; i > 0; i--) window_hist[i] = window_hist[i - 1];
    window_hist[0] = item.sample_in;
    if (seen_n < smf_pkg::WINDOW) seen_n++;
    if (!item.end_of_sequence) begin
      if (seen_n > smf_pkg::HALF) begin
        res.sample_out = (seen_n >= smf_pkg::WINDOW) ? window_median() :
                         window_hist[smf_pkg::HALF];
        res.last_out   = 1'b0;
        expected_samples.push_back(res);
      end
    end else begin
      first = (seen_n > smf_pkg::HALF) ? smf_pkg::HALF : seen_n - 1;
      for (int k = first; k >= 0; k--) begin
        res.sample_out = (k == smf_pkg::HALF && seen_n >= smf_pkg::WINDOW) ?
                         window_median() : window_hist[k];
        res.last_out   = (k == 0);
        expected_samples.push_back(res);
      end
      seen_n = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic smf_pkg::smf_in_t make_item(input logic signed [smf_pkg::SAMPLE_W-1:0] s,
                                                 input logic eos);
    smf_pkg::smf_in_t item;
    item.sample_in       = s;
    item.end_of_sequence = eos;
    return item;
  endfunction

  function automatic logic signed [smf_pkg::SAMPLE_W-1:0] pick_sample(input int mode);
    logic signed [smf_pkg::SAMPLE_W-1:0] s;
    case (mode)
      0: s = $urandom;
      1: s = $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7fff_ffff;
          2: s = '0;
          default: s = '1;
        endcase
      end
      default: s = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    return s;
  endfunction

  // Valid stays high across back-to-back items; drop it only for an idle burst.
  task automatic send_item(input smf_pkg::smf_in_t item);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_results(item);
    items_sent++;
  endtask

  task automatic send_sequence(input int len, input int mode);
    for (int i = 0; i < len; i++) send_item(make_item(pick_sample(mode), i == len - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic test_directed_edges();
    logic signed [smf_pkg::SAMPLE_W-1:0] mix[12] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0005, 32'sh0000_0005, 32'shffff_ffff,
      32'sh0000_0000, 32'sh0000_0005, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0005,
      32'sh0001_0000, 32'shffff_0000};
    send_item(make_item(32'sh8000_0000, 1'b1));
    send_item(make_item(32'sh7fff_ffff, 1'b0));
    send_item(make_item(32'shffff_ffff, 1'b0));
    send_item(make_item(32'sh0000_0000, 1'b0));
    send_item(make_item(32'sh8000_0000, 1'b1));
    for (int i = 0; i < 7; i++) send_item(make_item(32'sh0001_0000 * (i - 3), i == 6));
    for (int i = 0; i < 12; i++) send_item(make_item(mix[i], i == 11));
  endtask

  task automatic test_random_sequences(input int n_items);
    int stop_at;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 24);
      send_sequence(len, $urandom_range(0, 3));
    end
  endtask

  task automatic test_drain_pause();
    send_sequence(8, 0);
    send_item(make_item(pick_sample(0), 1'b0));
    wait_drained();
    send_sequence(14, 1);
    wait_drained();
  endtask

  task automatic test_full_rate(input int n_items);
    sender_idle_en = 1'b0;
    sink_stall_en  = 1'b0;
    test_random_sequences(n_items);
  endtask

  initial begin
    int burst;
    burst = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_en && burst == 0 && $urandom_range(0, 4) == 0)
        burst = $urandom_range(1, 6);
      if (burst > 0) begin
        out_ready <= 1'b0;
        burst--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    smf_pkg::smf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("no result expected", out_data.sample_out, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report_mismatch("sample_out", out_data.sample_out, want.sample_out);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_data.last_out), 32'(want.last_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL sliding_median_filter_core");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < smf_pkg::WINDOW; i++) window_hist[i] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_sequences(40);
    test_drain_pause();
    test_random_sequences(30);
    test_full_rate(30);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sliding_median_filter_core");
    end else begin
      $display("FAIL sliding_median_filter_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
